/* rtl/core/abb_pkg.sv */
`timescale 1ns / 1ps
// shared constants of the argb alpha blend blitter
package abb_pkg;

    // default surface store size
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // field widths
    localparam int PIX_W     = 32;
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 9;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SRC   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] SURFACE_SIZE_RESET = 9'd256;

    // blend masks and alpha codes
    localparam logic [PIX_W-1:0] MASK_RB      = 32'h00ff_00ff;
    localparam logic [PIX_W-1:0] MASK_G       = 32'h0000_ff00;
    localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hff;
    localparam int               ALPHA_LSB    = 24;

endpackage

/* rtl/core/abb_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module abb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/abb_blend.sv */
`timescale 1ns / 1ps
// argb compositing unit: registered products, then sum and merge
module abb_blend import abb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [PIX_W-1:0] i_src,
    input  logic [PIX_W-1:0] i_dst,
    output logic             o_keep,
    output logic [PIX_W-1:0] o_result
);

    logic [PIX_W-1:0] r_src, n_src;
    logic [PIX_W-1:0] r_dst, n_dst;
    logic [PIX_W-1:0] r_prb, n_prb;
    logic [PIX_W-1:0] r_pg, n_pg;
    logic [15:0]      r_pa, n_pa;

    logic [7:0]       src_a;
    logic [7:0]       out_a;
    logic [PIX_W-1:0] rb;
    logic [PIX_W-1:0] g;
    logic [7:0]       da;

    assign src_a = i_src[PIX_W-1:ALPHA_LSB];

    // wrapping 32-bit differences scaled by alpha
    always_comb begin
        n_src = i_src;
        n_dst = i_dst;
        n_prb = ((i_src & MASK_RB) - (i_dst & MASK_RB)) * {24'd0, src_a};
        n_pg  = ((i_src & MASK_G) - (i_dst & MASK_G)) * {24'd0, src_a};
        n_pa  = {8'd0, i_dst[PIX_W-1:ALPHA_LSB]} * {8'd0, ~src_a};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_src <= n_src;
            r_dst <= n_dst;
            r_prb <= n_prb;
            r_pg  <= n_pg;
            r_pa  <= n_pa;
        end
    end

    assign out_a = r_src[PIX_W-1:ALPHA_LSB];
    assign rb    = ((r_dst & MASK_RB) + (r_prb >> 8)) & MASK_RB;
    assign g     = ((r_dst & MASK_G) + (r_pg >> 8)) & MASK_G;
    assign da    = out_a + r_pa[15:8];

    assign o_keep   = (out_a == ALPHA_CLEAR);
    assign o_result = (out_a == ALPHA_OPAQUE) ? r_src : (rb | g | {da, 24'd0});

endmodule

/* rtl/core/argb_alpha_blend_blitter_unit.sv */
`timescale 1ns / 1ps
// argb alpha blend blitter: surface memory, command sequencer and read port
//
// The block holds an ARGB destination surface of MAX_WIDTH x MAX_HEIGHT
// 32-bit words in one synchronous memory, pixel (col,row) at word
// row*MAX_WIDTH+col. Commands arrive as words on the input channel: fill
// writes one colour over the surface in use, begin blit latches origin and
// rectangle size, source pixel composites one pixel into the surface at the
// next rectangle position (dropped when outside the surface), read returns
// one stored pixel (zero outside the surface) as a word on the output
// channel. After reset a clearing pass writes zero to every memory word,
// one word per cycle; no command is taken during that pass, configuration
// writes are. Commands share the single memory port pair: a source pixel
// that lands on the surface is read, then has its blend products
// registered, then is written back; a read that lands on the surface
// reads the memory, then holds the word for the output and waits on any
// output stall; fill sweeps width x height words. One command is worked
// at a time, so a source pixel never overlaps the write back of the one
// before. A finished read word sits in the output register while the next
// command is taken.
module argb_alpha_blend_blitter_unit import abb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [SIZE_W-1:0]    i_rect_width,
    input  logic [SIZE_W-1:0]    i_rect_height,
    // read result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_read_pixel,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_CLR     = 3'd0;
    localparam logic [ST_W-1:0] S_IDLE    = 3'd1;
    localparam logic [ST_W-1:0] S_FILL    = 3'd2;
    localparam logic [ST_W-1:0] S_SRC_MUL = 3'd3;
    localparam logic [ST_W-1:0] S_SRC_WR  = 3'd4;
    localparam logic [ST_W-1:0] S_RD      = 3'd5;
    localparam logic [ST_W-1:0] S_OUT     = 3'd6;

    // control registers
    logic [ST_W-1:0]   r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;
    logic [SIZE_W-1:0] r_surf_w, n_surf_w;
    logic [SIZE_W-1:0] r_surf_h, n_surf_h;
    logic [POS_W-1:0]  r_origin_col, n_origin_col;
    logic [POS_W-1:0]  r_origin_row, n_origin_row;
    logic [SIZE_W-1:0] r_src_w, n_src_w;
    logic [SIZE_W-1:0] r_src_h, n_src_h;
    logic [SIZE_W-1:0] r_col_count, n_col_count;
    logic [SIZE_W-1:0] r_row_count, n_row_count;

    // payload registers
    logic [PIX_W-1:0]  r_fill_pix, n_fill_pix;
    logic [SIZE_W-1:0] r_fcol, n_fcol;
    logic [SIZE_W-1:0] r_frow, n_frow;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic [AW-1:0]     r_addr, n_addr;
    logic [PIX_W-1:0]  r_hold, n_hold;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;

    // surface memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // blend unit
    logic              blend_load;
    logic              blend_keep;
    logic [PIX_W-1:0]  blend_result;

    // decode
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [POS_W:0]    src_col;
    logic [POS_W:0]    src_row;
    logic [POS_W:0]    rd_col;
    logic [POS_W:0]    rd_row;
    logic              blit_active;
    logic              src_hit;
    logic              rd_hit;
    logic [AW-1:0]     src_addr;
    logic [AW-1:0]     rd_addr;
    logic [SIZE_W:0]   col_inc;
    logic              in_take;
    logic              out_free;

    // position lies on the surface in use
    function automatic logic f_inside(
        input logic [POS_W:0]    col,
        input logic [POS_W:0]    row,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h
    );
        return !col[POS_W] && !row[POS_W]
            && (col[POS_W-1:0] < {1'b0, w}) && (row[POS_W-1:0] < {1'b0, h});
    endfunction

    // word address of a pixel that lies on the surface
    function automatic logic [AW-1:0] f_addr(
        input logic [POS_W:0] col,
        input logic [POS_W:0] row
    );
        return AW'(row[POS_W-1:0]) * AW'(MAX_WIDTH) + AW'(col[POS_W-1:0]);
    endfunction

    // size registers above the store saturate
    assign w_eff = (32'(r_surf_w) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : r_surf_w;
    assign h_eff = (32'(r_surf_h) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_surf_h;

    // next rectangle position in surface coordinates
    assign src_col = {r_origin_col[POS_W-1], r_origin_col} + {2'd0, r_col_count};
    assign src_row = {r_origin_row[POS_W-1], r_origin_row} + {2'd0, r_row_count};
    assign rd_col  = {i_pos_x[POS_W-1], i_pos_x};
    assign rd_row  = {i_pos_y[POS_W-1], i_pos_y};

    assign blit_active = (r_src_w != '0) && (r_row_count < r_src_h);
    assign src_hit     = blit_active && f_inside(src_col, src_row, w_eff, h_eff);
    assign rd_hit      = f_inside(rd_col, rd_row, w_eff, h_eff);
    assign src_addr    = f_addr(src_col, src_row);
    assign rd_addr     = f_addr(rd_col, rd_row);
    assign col_inc     = {1'b0, r_col_count} + 1'b1;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // read port: source pixel destination or read position
    assign ram_re    = in_take && (((i_command == CMD_SRC) && src_hit)
                                || ((i_command == CMD_READ) && rd_hit));
    assign ram_raddr = (i_command == CMD_READ) ? rd_addr : src_addr;

    // write port: clearing pass, fill sweep or blend write back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = blend_result;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr({2'd0, r_fcol}, {2'd0, r_frow});
                ram_wdata = r_fill_pix;
            end
            S_SRC_WR: begin
                ram_we    = !blend_keep;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    assign blend_load = (r_state == S_SRC_MUL);

    abb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_surface (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    abb_blend u_blend (
        .i_clk    (i_clk),
        .i_load   (blend_load),
        .i_src    (r_pix),
        .i_dst    (ram_rdata),
        .o_keep   (blend_keep),
        .o_result (blend_result)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid;
        n_surf_w     = r_surf_w;
        n_surf_h     = r_surf_h;
        n_origin_col = r_origin_col;
        n_origin_row = r_origin_row;
        n_src_w      = r_src_w;
        n_src_h      = r_src_h;
        n_col_count  = r_col_count;
        n_row_count  = r_row_count;
        n_fill_pix   = r_fill_pix;
        n_fcol       = r_fcol;
        n_frow       = r_frow;
        n_pix        = r_pix;
        n_addr       = r_addr;
        n_hold       = r_hold;
        n_out_pix    = r_out_pix;

        // output word taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_FILL: begin
                            n_fill_pix = i_pixel;
                            n_fcol     = '0;
                            n_frow     = '0;
                            if ((w_eff != '0) && (h_eff != '0)) begin
                                n_state = S_FILL;
                            end
                        end
                        CMD_BLIT: begin
                            n_origin_col = i_pos_x;
                            n_origin_row = i_pos_y;
                            n_src_w      = (32'(i_rect_width) > MAX_WIDTH)
                                         ? SIZE_W'(MAX_WIDTH) : i_rect_width;
                            n_src_h      = (32'(i_rect_height) > MAX_HEIGHT)
                                         ? SIZE_W'(MAX_HEIGHT) : i_rect_height;
                            n_col_count  = '0;
                            n_row_count  = '0;
                        end
                        CMD_SRC: begin
                            if (blit_active) begin
                                if (col_inc >= {1'b0, r_src_w}) begin
                                    n_col_count = '0;
                                    n_row_count = r_row_count + 1'b1;
                                end else begin
                                    n_col_count = col_inc[SIZE_W-1:0];
                                end
                            end
                            if (src_hit) begin
                                n_pix   = i_pixel;
                                n_addr  = src_addr;
                                n_state = S_SRC_MUL;
                            end
                        end
                        CMD_READ: begin
                            if (rd_hit) begin
                                n_state = S_RD;
                            end else begin
                                n_hold  = '0;
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_fcol == w_eff - 1'b1) begin
                    n_fcol = '0;
                    if (r_frow == h_eff - 1'b1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_frow = r_frow + 1'b1;
                    end
                end else begin
                    n_fcol = r_fcol + 1'b1;
                end
            end
            S_SRC_MUL: begin
                n_state = S_SRC_WR;
            end
            S_SRC_WR: begin
                n_state = S_IDLE;
            end
            S_RD: begin
                n_hold  = ram_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_hold;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes, taken in any state
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SURFACE_WIDTH: begin
                    n_surf_w = i_cfg_data;
                end
                REG_SURFACE_HEIGHT: begin
                    n_surf_h = i_cfg_data;
                end
                default: begin
                    n_surf_w = r_surf_w;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_surf_w     <= SURFACE_SIZE_RESET;
            r_surf_h     <= SURFACE_SIZE_RESET;
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_src_w      <= '0;
            r_src_h      <= '0;
            r_col_count  <= '0;
            r_row_count  <= '0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
            r_surf_w     <= n_surf_w;
            r_surf_h     <= n_surf_h;
            r_origin_col <= n_origin_col;
            r_origin_row <= n_origin_row;
            r_src_w      <= n_src_w;
            r_src_h      <= n_src_h;
            r_col_count  <= n_col_count;
            r_row_count  <= n_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_pix <= n_fill_pix;
        r_fcol     <= n_fcol;
        r_frow     <= n_frow;
        r_pix      <= n_pix;
        r_addr     <= n_addr;
        r_hold     <= n_hold;
        r_out_pix  <= n_out_pix;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_pixel = r_out_pix;
    assign o_cfg_ready  = 1'b1;

`ifndef SYNTH
    // column counter stays inside the rectangle row
    a_col_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_w != '0) |-> (r_col_count < r_src_w))
        else $error("column counter beyond rectangle width");

    // row counter never passes the rectangle height
    a_row_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_count <= r_src_h)
        else $error("row counter beyond rectangle height");

    // memory written only by clearing, fill or blend write back
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLR) || (r_state == S_FILL) || (r_state == S_SRC_WR)))
        else $error("surface write outside a writing state");

    // write back always follows the blend product stage
    a_wr_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRC_WR) |-> ($past(r_state) == S_SRC_MUL))
        else $error("write back without blend products");

    // clearing pass only runs on from reset
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLR) && (r_clr_addr != '0)) |-> ($past(r_state) == S_CLR))
        else $error("clearing pass entered after reset");
`endif

endmodule
